### rtl/core/skvt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key/value table package
// Item types, command and status codes shared by the table core, its cells
// and its checker.
// ----------------------------------------------------------------------------
package skvt_pkg;

  localparam int KEY_W     = 64;
  localparam int VALUE_W   = 64;
  localparam int ENTRIES_W = 5;

  // Command codes carried in the command field of an input item.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_LIST   = 2'd3;

  // Status codes carried in the status field of a result item.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [1:0]         command;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [KEY_W-1:0]     found_key;
    logic [VALUE_W-1:0]   found_value;
    logic [ENTRIES_W-1:0] entries_used;
    logic                 last;
  } rsp_item_t;

  // One stored pair.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic insert_en;
    logic delete_en;
    logic rotate_en;
  } cell_ctrl_t;

endpackage

### rtl/core/sorted_key_value_table_core.sv
// ----------------------------------------------------------------------------
// Sorted key/value table core
// A chain of cells that keeps up to CAPACITY unique key/value pairs sorted
// by ascending key, with insert, lookup, delete and list commands.
// ----------------------------------------------------------------------------
// Usage:
// Command items enter on cmd/cmd_valid/cmd_stall and result items leave on
// rsp/rsp_valid/rsp_stall; an item moves when valid is high and stall low.
// Insert, lookup and delete are finished in the cycle they are accepted and
// their result is registered in the output register; one such command can be
// accepted every cycle while no list streams and results keep being taken.
// List on a non-empty table first leaves the output empty and then streams
// one entry per cycle while results are taken, in key order, by rotating the
// used cells toward cell 0; last is set on its final result. A list on an
// empty table gives one result with status empty.
// While a list streams, or while a result is held by rsp_stall, cmd_stall is
// high. A stalled result holds its value until taken.
// Reset empties the table and drops any pending result; stored pairs are not
// cleared, since only cells below the entry count are ever used.
// ----------------------------------------------------------------------------
module sorted_key_value_table_core #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  skvt_pkg::cmd_item_t cmd,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output skvt_pkg::rsp_item_t rsp
);
  import skvt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                list_active;
  logic [CW-1:0]       list_left;

  entry_t              cell_q [CAPACITY];
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY:0]   seen;
  logic [CAPACITY-1:0] occ;

  logic                out_free;
  logic                cmd_take;
  logic                list_emit;
  logic                full;
  logic                empty;
  logic                any_eq;
  logic [VALUE_W-1:0]  found_val;
  cell_ctrl_t          ctrl;
  entry_t              new_entry;
  rsp_item_t           res_next;

  // Handshake and control broadcast.
  assign out_free  = !rsp_valid || !rsp_stall;
  assign cmd_stall = list_active || !out_free;
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign list_emit = list_active && out_free;
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign any_eq    = seen[CAPACITY];

  assign new_entry.key   = cmd.key;
  assign new_entry.value = cmd.value;

  assign ctrl.insert_en = cmd_take && (cmd.command == CMD_INSERT) && !full && !any_eq;
  assign ctrl.delete_en = cmd_take && (cmd.command == CMD_DELETE) && any_eq;
  assign ctrl.rotate_en = list_emit;

  assign seen[0] = 1'b0;

  // The chain of cells.
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    entry_t rot_e;
    logic   left_gt;

    assign occ[j] = (CW'(j) < count);

    if (j == 0) begin : g_head
      assign left_e  = cell_q[0];
      assign left_gt = 1'b1;
    end else begin : g_body
      assign left_e  = cell_q[j-1];
      assign left_gt = gt[j-1];
    end

    if (j == CAPACITY - 1) begin : g_tail
      assign right_e = cell_q[j];
      assign rot_e   = cell_q[0];
    end else begin : g_mid
      assign right_e = cell_q[j+1];
      assign rot_e   = (CW'(j + 1) < count) ? cell_q[j+1] : cell_q[0];
    end

    skvt_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occ[j]),
      .new_entry   (new_entry),
      .left_gt     (left_gt),
      .left_entry  (left_e),
      .right_entry (right_e),
      .rot_entry   (rot_e),
      .seen_in     (seen[j]),
      .gt          (gt[j]),
      .eq          (eq[j]),
      .seen_out    (seen[j+1]),
      .entry       (cell_q[j])
    );
  end

  // Value of the matching cell; at most one cell matches.
  always_comb begin
    found_val = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (eq[j]) begin
        found_val = found_val | cell_q[j].value;
      end
    end
  end

  // Result and new entry count of a single-result command.
  always_comb begin
    res_next.status      = ST_OK;
    res_next.found_key   = cmd.key;
    res_next.found_value = '0;
    res_next.last        = 1'b1;
    count_next           = count;
    case (cmd.command)
      CMD_INSERT: begin
        if (full) begin
          res_next.status = ST_FULL;
        end else if (any_eq) begin
          res_next.status = ST_DUP;
        end else begin
          count_next = count + CW'(1);
        end
      end
      CMD_LOOKUP: begin
        if (empty) begin
          res_next.status = ST_EMPTY;
        end else if (!any_eq) begin
          res_next.status = ST_NOTFOUND;
        end else begin
          res_next.found_value = found_val;
        end
      end
      CMD_DELETE: begin
        if (empty) begin
          res_next.status = ST_EMPTY;
        end else if (!any_eq) begin
          res_next.status = ST_NOTFOUND;
        end else begin
          res_next.found_value = found_val;
          count_next           = count - CW'(1);
        end
      end
      CMD_LIST: begin
        res_next.status    = ST_EMPTY;
        res_next.found_key = '0;
      end
      default: begin
        res_next.status = ST_OK;
      end
    endcase
    res_next.entries_used = ENTRIES_W'(count_next);
  end

  // Entry count, list sequencing and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid   <= 1'b0;
      list_active <= 1'b0;
      list_left   <= '0;
      count       <= '0;
    end else begin
      if (cmd_take) begin
        count <= count_next;
        if ((cmd.command == CMD_LIST) && !empty) begin
          list_active <= 1'b1;
          list_left   <= count;
          rsp_valid   <= 1'b0;
        end else begin
          rsp_valid <= 1'b1;
          rsp       <= res_next;
        end
      end else if (list_emit) begin
        rsp_valid         <= 1'b1;
        rsp.status        <= ST_OK;
        rsp.found_key     <= cell_q[0].key;
        rsp.found_value   <= cell_q[0].value;
        rsp.entries_used  <= ENTRIES_W'(count);
        rsp.last          <= (list_left == CW'(1));
        list_left         <= list_left - CW'(1);
        if (list_left == CW'(1)) begin
          list_active <= 1'b0;
        end
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/skvt_cell.sv
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one key/value pair, compares it against the broadcast key and takes
// data from a neighbor when the chain shifts for insert, delete or list.
// ----------------------------------------------------------------------------
module skvt_cell (
  input  logic               clk,
  input  skvt_pkg::cell_ctrl_t ctrl,
  input  logic               occupied,
  input  skvt_pkg::entry_t   new_entry,
  input  logic               left_gt,
  input  skvt_pkg::entry_t   left_entry,
  input  skvt_pkg::entry_t   right_entry,
  input  skvt_pkg::entry_t   rot_entry,
  input  logic               seen_in,
  output logic               gt,
  output logic               eq,
  output logic               seen_out,
  output skvt_pkg::entry_t   entry
);
  import skvt_pkg::*;

  // Compare the broadcast key with the stored one; empty cells never match.
  assign gt       = occupied && (new_entry.key > entry.key);
  assign eq       = occupied && (new_entry.key == entry.key);
  assign seen_out = seen_in || eq;

  // Insert opens a gap at the first cell not below the new key, delete pulls
  // from the right at and after the match, and list rotates the used cells.
  always_ff @(posedge clk) begin
    if (ctrl.insert_en) begin
      if (!left_gt) begin
        entry <= left_entry;
      end else if (!gt) begin
        entry <= new_entry;
      end
    end else if (ctrl.delete_en) begin
      if (seen_out) begin
        entry <= right_entry;
      end
    end else if (ctrl.rotate_en) begin
      entry <= rot_entry;
    end
  end

endmodule

### rtl/core/skvt_checker.sv
// ----------------------------------------------------------------------------
// Sorted key/value table checker
// Port-level assertions on the table core, bound to every instance.
// ----------------------------------------------------------------------------
module skvt_checker #(
  parameter int CAPACITY = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                cmd_stall,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input skvt_pkg::rsp_item_t rsp
);
  import skvt_pkg::*;

  // A stalled result item holds until taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result item changed while stalled");

  // Only list items continue past one result, and those are always ok.
  a_more_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> rsp.status == ST_OK)
    else $error("non-final result with error status");

  // No new command is taken while a list is still streaming.
  a_list_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> cmd_stall)
    else $error("command accepted during a list");

  // A full refusal reports a full table.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> rsp.entries_used == ENTRIES_W'(CAPACITY))
    else $error("full status with wrong entry count");

  // An empty report goes with a zero entry count.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_EMPTY) |-> rsp.entries_used == '0)
    else $error("empty status with nonzero entry count");

endmodule

bind sorted_key_value_table_core skvt_checker #(.CAPACITY(CAPACITY)) u_skvt_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_stall (cmd_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
